// ===== sv/qgu_pkg.sv =====
// qgu_pkg: shared constants, codes, types and helper functions of the qubit gate unit.
// No dependencies; every other file of the block but qgu_amp_mem refers to it by scoped names.

package qgu_pkg;

    // Parameter defaults
    localparam int QUBITS_DEF    = 8;
    localparam int AMP_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int MODE_W   = 3;
    localparam int IDX_W    = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;
    localparam int QCNT_W   = 4;
    localparam int NRES     = 6;
    localparam int RCNT_W   = 3;

    // Configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam int REG_SEL_W = PADDR_W - 2;
    localparam logic [REG_SEL_W-1:0] REG_QUBIT_COUNT = 1'b0;
    localparam logic [QCNT_W-1:0]    QUBIT_COUNT_RST = 4'd8;

    // Modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_X    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_Y    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_Z    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_H    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_S    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CNOT = 3'd6;
    localparam logic [MODE_W-1:0] MODE_BAD  = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MODE  = 2'd2;

    // Result counts per transaction kind
    localparam logic [RCNT_W-1:0] RCNT_NONE = 3'd0;
    localparam logic [RCNT_W-1:0] RCNT_ERR  = 3'd1;
    localparam logic [RCNT_W-1:0] RCNT_GATE = 3'd2;
    localparam logic [RCNT_W-1:0] RCNT_CNOT = 3'd6;

    // Control handed from the issue stage to the result buffer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                entangled;
        logic [RCNT_W-1:0]   count;
    } res_ctrl_t;

    // round(2^frac / sqrt 2), from a 2^30-scaled seed
    function automatic int hadamard_const(input int frac);
        longint c;
        int     sh;
        c  = 64'sd759250125;
        sh = 30 - frac;
        if (sh > 0)
        begin
            c = (c + (longint'(1) <<< (sh - 1))) >>> sh;
        end
        return int'(c);
    endfunction

endpackage

// ===== sv/qgu_if.sv =====
// qgu_if: valid/ready channel interfaces for command and result transactions.
// Depends on qgu_pkg for field widths and defaults.

interface qgu_in_if #(
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [qgu_pkg::MODE_W-1:0]    mode;
    logic [qgu_pkg::IDX_W-1:0]     first_index;
    logic [qgu_pkg::IDX_W-1:0]     second_index;
    logic signed [AMP_WIDTH-1:0]   load_zero_re;
    logic signed [AMP_WIDTH-1:0]   load_zero_im;
    logic signed [AMP_WIDTH-1:0]   load_one_re;
    logic signed [AMP_WIDTH-1:0]   load_one_im;

    modport source (
        output valid, mode, first_index, second_index,
               load_zero_re, load_zero_im, load_one_re, load_one_im,
        input  ready
    );
    modport sink (
        input  valid, mode, first_index, second_index,
               load_zero_re, load_zero_im, load_one_re, load_one_im,
        output ready
    );
endinterface

interface qgu_out_if #(
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [qgu_pkg::STATUS_W-1:0]  status;
    logic [qgu_pkg::SLOT_W-1:0]    slot;
    logic signed [AMP_WIDTH-1:0]   amp_re;
    logic signed [AMP_WIDTH-1:0]   amp_im;
    logic                          entangled;
    logic                          last;

    modport source (
        output valid, status, slot, amp_re, amp_im, entangled, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot, amp_re, amp_im, entangled, last,
        output ready
    );
endinterface

// ===== sv/qgu_amp_mem.sv =====
// qgu_amp_mem: qubit amplitude store, one write port and two registered read ports.
// Write-through on an address match at the same edge. Depends on nothing else.

module qgu_amp_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
            rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
        end
    end

endmodule

// ===== sv/qgu_gate_calc.sv =====
// qgu_gate_calc: gate arithmetic (Pauli, Hadamard, S) and CNOT joint amplitudes.
// Round half up, saturate. Depends on qgu_pkg for mode codes and the Hadamard constant.

module qgu_gate_calc #(
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
) (
    input  logic [qgu_pkg::MODE_W-1:0] mode,
    input  logic signed [AMP_WIDTH-1:0] ctl [4],
    input  logic signed [AMP_WIDTH-1:0] tgt [4],
    output logic signed [AMP_WIDTH-1:0] gate_amp [4],
    output logic signed [AMP_WIDTH-1:0] joint_re [4],
    output logic signed [AMP_WIDTH-1:0] joint_im [4]
);

    localparam int W    = AMP_WIDTH;
    localparam int FRAC = W - 2;
    localparam int PW   = 2 * W;
    localparam int SW   = PW + 1;
    localparam int QW   = SW - FRAC;

    localparam logic signed [W-1:0]  HCONST = W'(qgu_pkg::hadamard_const(FRAC));
    localparam logic signed [SW-1:0] HALF   = {{(SW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [QW-1:0] QMAX   = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [QW-1:0] QMIN   = {{(QW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  AMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  AMIN   = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] p);
        return {p[PW-1], p};
    endfunction

    // floor((s + half) / 2^FRAC), clamped to the amplitude range
    function automatic logic signed [W-1:0] rnd(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] t;
        logic signed [QW-1:0] q;
        t = s + HALF;
        q = t[SW-1:FRAC];
        if (q > QMAX)
        begin
            return AMAX;
        end
        else if (q < QMIN)
        begin
            return AMIN;
        end
        return q[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] neg(input logic signed [W-1:0] x);
        return (x == AMIN) ? AMAX : -x;
    endfunction

    // Hadamard products
    logic signed [PW-1:0] hp [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            hp[k] = HCONST * ctl[k];
        end
    end

    always_comb
    begin
        case (mode)
            qgu_pkg::MODE_X:
            begin
                gate_amp[0] = ctl[2];
                gate_amp[1] = ctl[3];
                gate_amp[2] = ctl[0];
                gate_amp[3] = ctl[1];
            end
            qgu_pkg::MODE_Y:
            begin
                gate_amp[0] = ctl[3];
                gate_amp[1] = neg(ctl[2]);
                gate_amp[2] = neg(ctl[1]);
                gate_amp[3] = ctl[0];
            end
            qgu_pkg::MODE_Z:
            begin
                gate_amp[0] = ctl[0];
                gate_amp[1] = ctl[1];
                gate_amp[2] = neg(ctl[2]);
                gate_amp[3] = neg(ctl[3]);
            end
            qgu_pkg::MODE_H:
            begin
                gate_amp[0] = rnd(ext(hp[0]) + ext(hp[2]));
                gate_amp[1] = rnd(ext(hp[1]) + ext(hp[3]));
                gate_amp[2] = rnd(ext(hp[0]) - ext(hp[2]));
                gate_amp[3] = rnd(ext(hp[1]) - ext(hp[3]));
            end
            qgu_pkg::MODE_S:
            begin
                gate_amp[0] = ctl[0];
                gate_amp[1] = ctl[1];
                gate_amp[2] = neg(ctl[3]);
                gate_amp[3] = ctl[2];
            end
            default:
            begin
                gate_amp = ctl;
            end
        endcase
    end

    // Tensor product; |10> and |11> come out swapped
    for (genvar i = 0; i < 4; i++)
    begin : g_joint
        localparam int XO  = (i / 2) * 2;
        localparam int YO  = (i % 2) * 2;
        localparam int DST = (i == 2) ? 3 : ((i == 3) ? 2 : i);

        logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;

        assign p_rr = ctl[XO]   * tgt[YO];
        assign p_ii = ctl[XO+1] * tgt[YO+1];
        assign p_ri = ctl[XO]   * tgt[YO+1];
        assign p_ir = ctl[XO+1] * tgt[YO];

        assign joint_re[DST] = rnd(ext(p_rr) - ext(p_ii));
        assign joint_im[DST] = rnd(ext(p_ri) + ext(p_ir));
    end

endmodule

// ===== sv/qgu_out_buf.sv =====
// qgu_out_buf: result register bank that plays out up to six result transactions.
// Depends on qgu_pkg (res_ctrl_t, counts) and qgu_out_if.

module qgu_out_buf #(
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  qgu_pkg::res_ctrl_t          push_ctrl,
    input  logic signed [AMP_WIDTH-1:0] push_re [qgu_pkg::NRES],
    input  logic signed [AMP_WIDTH-1:0] push_im [qgu_pkg::NRES],
    output logic                        can_load,
    qgu_out_if.source                   out_ch
);

    logic [qgu_pkg::RCNT_W-1:0]   cnt_reg, cnt_next;
    logic [qgu_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [qgu_pkg::STATUS_W-1:0] status_reg;
    logic                         ent_reg;
    logic signed [AMP_WIDTH-1:0]  re_reg [qgu_pkg::NRES];
    logic signed [AMP_WIDTH-1:0]  im_reg [qgu_pkg::NRES];
    logic                         pop;

    assign pop      = out_ch.valid && out_ch.ready;
    assign can_load = (cnt_reg == qgu_pkg::RCNT_NONE)
                   || ((cnt_reg == qgu_pkg::RCNT_ERR) && out_ch.ready);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (push)
        begin
            cnt_next = push_ctrl.count;
            idx_next = '0;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 1'b1;
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            status_reg <= push_ctrl.status;
            ent_reg    <= push_ctrl.entangled;
            re_reg     <= push_re;
            im_reg     <= push_im;
        end
    end

    assign out_ch.valid     = (cnt_reg != qgu_pkg::RCNT_NONE);
    assign out_ch.status    = status_reg;
    assign out_ch.slot      = idx_reg;
    assign out_ch.amp_re    = re_reg[idx_reg];
    assign out_ch.amp_im    = im_reg[idx_reg];
    assign out_ch.entangled = ent_reg;
    assign out_ch.last      = (cnt_reg == qgu_pkg::RCNT_ERR);

endmodule

// ===== sv/qubit_gate_unit_top.sv =====
// qubit_gate_unit_top: qubit gate unit, top level with config register and issue stage.
// Depends on qgu_pkg, qgu_if, qgu_amp_mem, qgu_gate_calc, qgu_out_buf.
//
//   channel   kind        direction  transaction
//   -------   ---------   ---------  ---------------------------------------------
//   in_ch     valid/ready into block one command: load, gate, CNOT
//   out_ch    valid/ready out        one result: status, slot, amplitude, flags
//   APB       psel/pen.   into block qubit_count register at byte 0
//
// Cycles: the store is read at the edge that accepts a command, so the issue stage holds
// its amplitudes in the next cycle; once the result bank can load, the edge that moves
// its results into the bank makes the first result valid on out_ch. The result port
// drains one result per cycle while out_ch.ready is high: a load gives no result, an
// error one, a single-qubit gate two, CNOT six.
// Reset clears qubit_count to 8 and all entangled flags; amplitudes are undefined until
// loaded. A stalled out_ch holds the bank; the issue stage then holds and in_ch.ready drops.

module qubit_gate_unit_top #(
    parameter int QUBITS    = qgu_pkg::QUBITS_DEF,
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qgu_pkg::PADDR_W-1:0]   paddr,
    input  logic [qgu_pkg::APB_DW-1:0]    pwdata,
    output logic [qgu_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    qgu_in_if.sink                        in_ch,
    qgu_out_if.source                     out_ch
);

    localparam int W  = AMP_WIDTH;
    localparam int AW = $clog2(QUBITS);
    localparam int DW = 4 * W;

    // ---------------- configuration register ----------------
    logic [qgu_pkg::QCNT_W-1:0] qubit_count_reg;
    logic                       cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[qgu_pkg::PADDR_W-1:2] == qgu_pkg::REG_QUBIT_COUNT);
    assign prdata  = cfg_hit ? qgu_pkg::APB_DW'(qubit_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubit_count_reg <= qgu_pkg::QUBIT_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            qubit_count_reg <= pwdata[qgu_pkg::QCNT_W-1:0];
        end
    end

    // ---------------- issue stage ----------------
    logic                        accept;
    logic                        can_load;
    logic                        advance;
    logic                        s1_valid_reg;
    logic [qgu_pkg::MODE_W-1:0]  s1_mode_reg;
    logic [qgu_pkg::IDX_W-1:0]   s1_a_reg;
    logic [qgu_pkg::IDX_W-1:0]   s1_b_reg;
    logic [DW-1:0]               s1_load_reg;

    assign accept      = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !s1_valid_reg || can_load;
    assign advance     = s1_valid_reg && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= in_ch.mode;
            s1_a_reg    <= in_ch.first_index;
            s1_b_reg    <= in_ch.second_index;
            s1_load_reg <= {in_ch.load_one_im, in_ch.load_one_re,
                            in_ch.load_zero_im, in_ch.load_zero_re};
        end
    end

    // ---------------- amplitude store ----------------
    logic          mem_we;
    logic [DW-1:0] mem_wdata;
    logic [DW-1:0] rd_a, rd_b;
    logic [AW-1:0] a_idx, b_idx;

    assign a_idx = AW'(s1_a_reg);
    assign b_idx = AW'(s1_b_reg);

    qgu_amp_mem #(
        .DEPTH (QUBITS),
        .AW    (AW),
        .DW    (DW)
    ) u_amp_mem (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (a_idx),
        .wdata   (mem_wdata),
        .re      (accept),
        .raddr_a (AW'(in_ch.first_index)),
        .raddr_b (AW'(in_ch.second_index)),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // ---------------- checks ----------------
    logic                         a_ok, b_ok, is_gate;
    logic [qgu_pkg::STATUS_W-1:0] status;

    assign a_ok = ({1'b0, s1_a_reg} < qubit_count_reg) && (32'(s1_a_reg) < 32'(QUBITS));
    assign b_ok = ({1'b0, s1_b_reg} < qubit_count_reg) && (32'(s1_b_reg) < 32'(QUBITS));
    assign is_gate = s1_mode_reg inside {[qgu_pkg::MODE_X:qgu_pkg::MODE_S]};

    always_comb
    begin
        if (s1_mode_reg == qgu_pkg::MODE_BAD)
        begin
            status = qgu_pkg::STAT_MODE;
        end
        else if (!a_ok || ((s1_mode_reg == qgu_pkg::MODE_CNOT) && !b_ok))
        begin
            status = qgu_pkg::STAT_RANGE;
        end
        else
        begin
            status = qgu_pkg::STAT_OK;
        end
    end

    // ---------------- arithmetic ----------------
    logic signed [W-1:0] ctl [4];
    logic signed [W-1:0] tgt [4];
    logic signed [W-1:0] gate_amp [4];
    logic signed [W-1:0] joint_re [4];
    logic signed [W-1:0] joint_im [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ctl[k] = rd_a[k*W +: W];
            tgt[k] = rd_b[k*W +: W];
        end
    end

    qgu_gate_calc #(
        .AMP_WIDTH (AMP_WIDTH)
    ) u_gate_calc (
        .mode     (s1_mode_reg),
        .ctl      (ctl),
        .tgt      (tgt),
        .gate_amp (gate_amp),
        .joint_re (joint_re),
        .joint_im (joint_im)
    );

    // ---------------- entangled flags ----------------
    logic [QUBITS-1:0] flag_reg, flag_next;

    // CNOT of a qubit with itself sets the one flag
    always_comb
    begin
        flag_next = flag_reg;
        if (advance && (status == qgu_pkg::STAT_OK))
        begin
            if (s1_mode_reg == qgu_pkg::MODE_LOAD)
            begin
                flag_next[a_idx] = 1'b0;
            end
            else if (s1_mode_reg == qgu_pkg::MODE_CNOT)
            begin
                flag_next[a_idx] = 1'b1;
                flag_next[b_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    // write back: loads and single-qubit gates only; CNOT leaves qubits as they are
    assign mem_we    = advance && (status == qgu_pkg::STAT_OK)
                    && ((s1_mode_reg == qgu_pkg::MODE_LOAD) || is_gate);
    assign mem_wdata = (s1_mode_reg == qgu_pkg::MODE_LOAD) ? s1_load_reg
                     : {gate_amp[3], gate_amp[2], gate_amp[1], gate_amp[0]};

    // ---------------- result assembly ----------------
    qgu_pkg::res_ctrl_t  res_ctrl;
    logic signed [W-1:0] res_re [qgu_pkg::NRES];
    logic signed [W-1:0] res_im [qgu_pkg::NRES];

    always_comb
    begin
        res_ctrl.status    = status;
        res_ctrl.entangled = 1'b0;
        res_ctrl.count     = qgu_pkg::RCNT_ERR;
        for (int k = 0; k < qgu_pkg::NRES; k++)
        begin
            res_re[k] = '0;
            res_im[k] = '0;
        end
        if (status == qgu_pkg::STAT_OK)
        begin
            case (s1_mode_reg)
                qgu_pkg::MODE_LOAD:
                begin
                    res_ctrl.count = qgu_pkg::RCNT_NONE;
                end
                qgu_pkg::MODE_CNOT:
                begin
                    res_ctrl.count     = qgu_pkg::RCNT_CNOT;
                    res_ctrl.entangled = 1'b1;
                    res_re[0] = tgt[0];
                    res_im[0] = tgt[1];
                    res_re[1] = tgt[2];
                    res_im[1] = tgt[3];
                    for (int k = 0; k < 4; k++)
                    begin
                        res_re[k+2] = joint_re[k];
                        res_im[k+2] = joint_im[k];
                    end
                end
                default:
                begin
                    res_ctrl.count     = qgu_pkg::RCNT_GATE;
                    res_ctrl.entangled = flag_reg[a_idx];
                    res_re[0] = gate_amp[0];
                    res_im[0] = gate_amp[1];
                    res_re[1] = gate_amp[2];
                    res_im[1] = gate_amp[3];
                end
            endcase
        end
    end

    qgu_out_buf #(
        .AMP_WIDTH (AMP_WIDTH)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_ctrl (res_ctrl),
        .push_re   (res_re),
        .push_im   (res_im),
        .can_load  (can_load),
        .out_ch    (out_ch)
    );

endmodule

// ===== sv/qgu_checker.sv =====
// qgu_checker: port-level assertions for the qubit gate unit, bound to the top level.
// Depends on qgu_pkg for codes and widths.

module qgu_checker #(
    parameter int AMP_WIDTH = qgu_pkg::AMP_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [qgu_pkg::STATUS_W-1:0] out_status,
    input logic [qgu_pkg::SLOT_W-1:0]   out_slot,
    input logic signed [AMP_WIDTH-1:0]  out_amp_re,
    input logic                         out_last
);

    // a result waiting on ready stays up
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its slot, real amplitude and status
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_slot) && $stable(out_amp_re)
                                       && $stable(out_status)))
        else $error("result payload changed while stalled");

    // results of one command come back to back with rising slot numbers
    a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last)
            |=> (out_valid && (out_slot == $past(out_slot) + 3'd1)))
        else $error("slot sequence broken within a command");

    // an error is a single result in slot 0; a good command ends on slot 1 or 5
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_last) |->
            (((out_status != qgu_pkg::STAT_OK) && (out_slot == 3'd0))
          || ((out_status == qgu_pkg::STAT_OK) && ((out_slot == 3'd1) || (out_slot == 3'd5)))))
        else $error("final result in an unexpected slot");

endmodule

bind qubit_gate_unit_top qgu_checker #(
    .AMP_WIDTH (AMP_WIDTH)
) u_qgu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_slot   (out_ch.slot),
    .out_amp_re (out_ch.amp_re),
    .out_last   (out_ch.last)
);

// ===== sim/qubit_gate_unit_top_tb.sv =====
// qubit_gate_unit_top_tb: self-checking bench for the qubit gate unit.
// Needs qgu_pkg, qgu_if and the qubit_gate_unit_top RTL; nothing else.
// Commands go in, results come back and are checked against an in-bench gate predictor.
`timescale 1ns / 1ps

module qubit_gate_unit_top_tb;

    localparam int QUBITS = qgu_pkg::QUBITS_DEF;
    localparam int AMP_W  = qgu_pkg::AMP_WIDTH_DEF;
    localparam int FRAC   = AMP_W - 2;

    // round(2^14 / sqrt 2), the Hadamard coefficient in Q2.14
    localparam longint H_COEF = 11585;

    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};
    localparam logic [qgu_pkg::PADDR_W-1:0] QCNT_ADDR = {qgu_pkg::REG_QUBIT_COUNT, 2'b00};

    // One command transaction as it sits on in_ch
    typedef struct packed {
        logic [qgu_pkg::MODE_W-1:0] mode;
        logic [qgu_pkg::IDX_W-1:0]  idx_a;
        logic [qgu_pkg::IDX_W-1:0]  idx_b;
        logic [AMP_W-1:0]           z_re;
        logic [AMP_W-1:0]           z_im;
        logic [AMP_W-1:0]           o_re;
        logic [AMP_W-1:0]           o_im;
    } cmd_t;

    // One result transaction as it should appear on out_ch
    typedef struct packed {
        logic [qgu_pkg::STATUS_W-1:0] status;
        logic [qgu_pkg::SLOT_W-1:0]   slot;
        logic [AMP_W-1:0]             re;
        logic [AMP_W-1:0]             im;
        logic                         ent;
        logic                         last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [qgu_pkg::PADDR_W-1:0]   paddr;
    logic [qgu_pkg::APB_DW-1:0]    pwdata;
    logic [qgu_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    qgu_in_if  #(.AMP_WIDTH(AMP_W)) in_ch ();
    qgu_out_if #(.AMP_WIDTH(AMP_W)) out_ch ();

    qubit_gate_unit_top #(
        .QUBITS    (QUBITS),
        .AMP_WIDTH (AMP_W)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    cmd_t    cmd_q[$];          // commands waiting for the driver
    result_t gate_results_q[$]; // predicted results, oldest first

    int send_idle_pct  = 0;     // chance per cycle the driver holds valid low
    int recv_stall_pct = 0;     // chance per cycle the monitor holds ready low

    int mismatches      = 0;
    int cmds_accepted   = 0;
    int results_checked = 0;
    int cnots_issued    = 0;
    int cmds_rejected   = 0;
    int limits_applied  = 0;

    // ------------------------------------------------------------------
    // Gate predictor: its own copy of the qubit store, flags, joint state
    // and the qubit_count register.
    // ------------------------------------------------------------------
    logic signed [AMP_W-1:0]    qubit_amps [QUBITS][4];
    logic                       ent_flags  [QUBITS];
    logic signed [AMP_W-1:0]    joint_amps [4][2];
    logic [qgu_pkg::QCNT_W-1:0] qubit_limit;

    function automatic logic signed [AMP_W-1:0] clamp_amp(input longint v);
        longint lim;
        lim = longint'(1) <<< (AMP_W - 1);
        if (v > lim - 1)
        begin
            return AMP_MAX;
        end
        if (v < -lim)
        begin
            return AMP_MIN;
        end
        return v[AMP_W-1:0];
    endfunction

    function automatic logic signed [AMP_W-1:0] negate_amp(input logic signed [AMP_W-1:0] v);
        return clamp_amp(-longint'(v));
    endfunction

    // (p1 + p2) / 2^FRAC, rounded half up, saturated
    function automatic logic signed [AMP_W-1:0] round_pair(input longint p1, input longint p2);
        return clamp_amp((p1 + p2 + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic longint mul(input logic signed [AMP_W-1:0] x,
                                   input logic signed [AMP_W-1:0] y);
        return longint'(x) * longint'(y);
    endfunction

    function automatic bit index_in_use(input logic [qgu_pkg::IDX_W-1:0] idx);
        return ({1'b0, idx} < qubit_limit) && (int'(idx) < QUBITS);
    endfunction

    task automatic push_result(input logic [qgu_pkg::STATUS_W-1:0] st, input int slot,
                               input logic [AMP_W-1:0] re, input logic [AMP_W-1:0] im,
                               input logic ent, input logic last);
        result_t r;
        r.status = st;
        r.slot   = qgu_pkg::SLOT_W'(slot);
        r.re     = re;
        r.im     = im;
        r.ent    = ent;
        r.last   = last;
        gate_results_q.insert(gate_results_q.size(), r);
    endtask

    // Advance the predictor by one accepted command and queue what it yields
    task automatic apply_command(input cmd_t c);
        logic signed [AMP_W-1:0] q [4];
        logic signed [AMP_W-1:0] t [4];
        logic signed [AMP_W-1:0] n [4];
        logic signed [AMP_W-1:0] xr, xi, yr, yi;
        int ci, ti, dst;
        // bad mode wins over a bad index
        if (c.mode == qgu_pkg::MODE_BAD)
        begin
            cmds_rejected++;
            push_result(qgu_pkg::STAT_MODE, 0, '0, '0, 1'b0, 1'b1);
            return;
        end
        if (!index_in_use(c.idx_a)
            || (c.mode == qgu_pkg::MODE_CNOT && !index_in_use(c.idx_b)))
        begin
            cmds_rejected++;
            push_result(qgu_pkg::STAT_RANGE, 0, '0, '0, 1'b0, 1'b1);
            return;
        end
        if (c.mode == qgu_pkg::MODE_LOAD)
        begin
            qubit_amps[c.idx_a][0] = $signed(c.z_re);
            qubit_amps[c.idx_a][1] = $signed(c.z_im);
            qubit_amps[c.idx_a][2] = $signed(c.o_re);
            qubit_amps[c.idx_a][3] = $signed(c.o_im);
            ent_flags[c.idx_a] = 1'b0;
            return;
        end
        for (int k = 0; k < 4; k++)
        begin
            q[k] = qubit_amps[c.idx_a][k];
            t[k] = qubit_amps[c.idx_b][k];
        end
        if (c.mode == qgu_pkg::MODE_CNOT)
        begin
            cnots_issued++;
            // control (x) target, then |10> and |11> trade places
            for (int i = 0; i < 4; i++)
            begin
                ci  = 2 * (i >> 1);
                ti  = 2 * (i & 1);
                xr  = q[ci];
                xi  = q[ci+1];
                yr  = t[ti];
                yi  = t[ti+1];
                dst = (i == 2) ? 3 : (i == 3) ? 2 : i;
                joint_amps[dst][0] = round_pair(mul(xr, yr), -mul(xi, yi));
                joint_amps[dst][1] = round_pair(mul(xr, yi), mul(xi, yr));
            end
            ent_flags[c.idx_a] = 1'b1;
            ent_flags[c.idx_b] = 1'b1;
            push_result(qgu_pkg::STAT_OK, 0, t[0], t[1], 1'b1, 1'b0);
            push_result(qgu_pkg::STAT_OK, 1, t[2], t[3], 1'b1, 1'b0);
            for (int i = 0; i < 4; i++)
            begin
                push_result(qgu_pkg::STAT_OK, 2 + i, joint_amps[i][0], joint_amps[i][1],
                            1'b1, i == 3);
            end
            return;
        end
        case (c.mode)
            qgu_pkg::MODE_X:
            begin
                n[0] = q[2];
                n[1] = q[3];
                n[2] = q[0];
                n[3] = q[1];
            end
            qgu_pkg::MODE_Y:
            begin
                n[0] = q[3];
                n[1] = negate_amp(q[2]);
                n[2] = negate_amp(q[1]);
                n[3] = q[0];
            end
            qgu_pkg::MODE_Z:
            begin
                n[0] = q[0];
                n[1] = q[1];
                n[2] = negate_amp(q[2]);
                n[3] = negate_amp(q[3]);
            end
            qgu_pkg::MODE_H:
            begin
                n[0] = round_pair(H_COEF * q[0], H_COEF * q[2]);
                n[1] = round_pair(H_COEF * q[1], H_COEF * q[3]);
                n[2] = round_pair(H_COEF * q[0], -(H_COEF * q[2]));
                n[3] = round_pair(H_COEF * q[1], -(H_COEF * q[3]));
            end
            default:
            begin
                n[0] = q[0];
                n[1] = q[1];
                n[2] = negate_amp(q[3]);
                n[3] = q[2];
            end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            qubit_amps[c.idx_a][k] = n[k];
        end
        push_result(qgu_pkg::STAT_OK, 0, n[0], n[1], ent_flags[c.idx_a], 1'b0);
        push_result(qgu_pkg::STAT_OK, 1, n[2], n[3], ent_flags[c.idx_a], 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Command driver: holds a transaction until accepted, then either
    // presents the next queued one or drops valid and idles.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_commands
        cmd_t taken;
        cmd_t nxt;
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.mode         <= qgu_pkg::MODE_LOAD;
            in_ch.first_index  <= '0;
            in_ch.second_index <= '0;
            in_ch.load_zero_re <= '0;
            in_ch.load_zero_im <= '0;
            in_ch.load_one_re  <= '0;
            in_ch.load_one_im  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                taken.mode  = in_ch.mode;
                taken.idx_a = in_ch.first_index;
                taken.idx_b = in_ch.second_index;
                taken.z_re  = in_ch.load_zero_re;
                taken.z_im  = in_ch.load_zero_im;
                taken.o_re  = in_ch.load_one_re;
                taken.o_im  = in_ch.load_one_im;
                cmds_accepted++;
                apply_command(taken);
            end
            // a pending transaction stays on the bus until taken
            if (!in_ch.valid || in_ch.ready)
            begin
                if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = cmd_q.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.mode         <= nxt.mode;
                    in_ch.first_index  <= nxt.idx_a;
                    in_ch.second_index <= nxt.idx_b;
                    in_ch.load_zero_re <= nxt.z_re;
                    in_ch.load_zero_im <= nxt.z_im;
                    in_ch.load_one_re  <= nxt.o_re;
                    in_ch.load_one_im  <= nxt.o_im;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_checked++;
                if (gate_results_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result: st=%0d slot=%0d re=%0d im=%0d",
                                 $time, out_ch.status, out_ch.slot,
                                 $signed(out_ch.amp_re), $signed(out_ch.amp_im));
                    mismatches++;
                end
                else
                begin
                    want = gate_results_q.pop_front();
                    if (out_ch.status !== want.status || out_ch.slot !== want.slot ||
                        out_ch.amp_re !== want.re || out_ch.amp_im !== want.im ||
                        out_ch.entangled !== want.ent || out_ch.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"[%0t] result mismatch: exp st=%0d slot=%0d re=%0d im=%0d",
                                      " ent=%0b last=%0b | got st=%0d slot=%0d re=%0d im=%0d",
                                      " ent=%0b last=%0b"},
                                     $time, want.status, want.slot, $signed(want.re),
                                     $signed(want.im), want.ent, want.last,
                                     out_ch.status, out_ch.slot, $signed(out_ch.amp_re),
                                     $signed(out_ch.amp_im), out_ch.entangled, out_ch.last);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation. gen_loaded mirrors which qubits hold written
    // amplitudes, so that no gate or CNOT ever reads an unwritten entry.
    // ------------------------------------------------------------------
    int gen_limit = int'(qgu_pkg::QUBIT_COUNT_RST);
    bit gen_loaded [QUBITS];

    function automatic cmd_t make_cmd(input logic [qgu_pkg::MODE_W-1:0] m, input int a,
                                      input int b, input int p0r, input int p0i,
                                      input int p1r, input int p1i);
        cmd_t c;
        c.mode  = m;
        c.idx_a = qgu_pkg::IDX_W'(a);
        c.idx_b = qgu_pkg::IDX_W'(b);
        c.z_re  = AMP_W'(p0r);
        c.z_im  = AMP_W'(p0i);
        c.o_re  = AMP_W'(p1r);
        c.o_im  = AMP_W'(p1i);
        return c;
    endfunction

    function automatic int rand_amp();
        case ($urandom_range(0, 9))
            0:       return int'(AMP_MIN);
            1:       return int'(AMP_MAX);
            2:       return 0;
            3, 4, 5: return int'($urandom);
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    task automatic queue_cmd(input cmd_t c);
        if (c.mode == qgu_pkg::MODE_LOAD && int'(c.idx_a) < gen_limit)
            gen_loaded[c.idx_a] = 1'b1;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    // Mostly well-formed traffic on loaded qubits, plus bad modes and bad indices
    task automatic queue_random_cmd();
        cmd_t c;
        int   usable[$];
        int   r;
        for (int i = 0; i < QUBITS; i++)
        begin
            if (gen_loaded[i] && i < gen_limit)
                usable.insert(usable.size(), i);
        end
        c = make_cmd(qgu_pkg::MODE_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                     rand_amp(), rand_amp(), rand_amp(), rand_amp());
        r = $urandom_range(0, 99);
        if (r < 22 || (usable.size() == 0 && r < 88))
        begin
            if (gen_limit > 0)
                c.idx_a = qgu_pkg::IDX_W'($urandom_range(0, gen_limit - 1));
        end
        else if (r < 75)
        begin
            c.mode  = qgu_pkg::MODE_W'($urandom_range(int'(qgu_pkg::MODE_X),
                                                      int'(qgu_pkg::MODE_S)));
            c.idx_a = qgu_pkg::IDX_W'(usable[$urandom_range(0, usable.size() - 1)]);
        end
        else if (r < 88)
        begin
            c.mode  = qgu_pkg::MODE_CNOT;
            c.idx_a = qgu_pkg::IDX_W'(usable[$urandom_range(0, usable.size() - 1)]);
            c.idx_b = qgu_pkg::IDX_W'(usable[$urandom_range(0, usable.size() - 1)]);
        end
        else if (r < 93 || gen_limit >= QUBITS)
        begin
            c.mode = qgu_pkg::MODE_BAD;
        end
        else if (r < 97 || usable.size() == 0)
        begin
            // first index past qubit_count, any real mode
            c.mode  = qgu_pkg::MODE_W'($urandom_range(int'(qgu_pkg::MODE_LOAD),
                                                      int'(qgu_pkg::MODE_CNOT)));
            c.idx_a = qgu_pkg::IDX_W'($urandom_range(gen_limit, QUBITS - 1));
        end
        else
        begin
            // CNOT with a good control but a target past qubit_count
            c.mode  = qgu_pkg::MODE_CNOT;
            c.idx_a = qgu_pkg::IDX_W'(usable[$urandom_range(0, usable.size() - 1)]);
            c.idx_b = qgu_pkg::IDX_W'($urandom_range(gen_limit, QUBITS - 1));
        end
        queue_cmd(c);
    endtask

    // Wait until every command is taken and every result has come back, then
    // let the pipeline clear on further clock edges.
    task automatic wait_idle();
        while (cmd_q.size() > 0 || in_ch.valid)
            @(negedge clk);
        while (gate_results_q.size() > 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write of qubit_count followed by a read-back
    task automatic set_qubit_limit(input int v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QCNT_ADDR;
        pwdata  <= qgu_pkg::APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[qgu_pkg::QCNT_W-1:0] !== qgu_pkg::QCNT_W'(v))
        begin
            if (mismatches < 10)
                $display("[%0t] qubit_count read-back: exp %0d got %0d",
                         $time, v, prdata[qgu_pkg::QCNT_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        qubit_limit = qgu_pkg::QCNT_W'(v);
        gen_limit   = v;
        limits_applied++;
    endtask

    task automatic run_random_phase(input int limit, input int idle, input int stall,
                                    input int n);
        set_qubit_limit(limit);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        @(negedge clk);
        repeat (n) queue_random_cmd();
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        // known levels on the config port from time zero; the channel
        // processes set in_ch and out_ch.ready while reset is low
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        qubit_limit        = qgu_pkg::QUBIT_COUNT_RST;
        for (int i = 0; i < QUBITS; i++)
        begin
            ent_flags[i]  = 1'b0;
            gen_loaded[i] = 1'b0;
            for (int k = 0; k < 4; k++)
                qubit_amps[i][k] = '0;
        end
        for (int i = 0; i < 4; i++)
        begin
            joint_amps[i][0] = '0;
            joint_amps[i][1] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: basis states, full-scale corners, every gate, CNOT with
        // itself, bad mode, then bad indices under a reduced qubit_count
        set_qubit_limit(8);
        @(negedge clk);
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 0, 0, 16384, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 1, 0, 0, 0, 16384, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 2, 0, 32767, -32768, -32768, 32767));
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 7, 7, -32768, -32768, -32768, -32768));
        queue_cmd(make_cmd(qgu_pkg::MODE_X, 0, 7, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_Y, 2, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_Z, 7, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_H, 2, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_S, 7, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_H, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_Y, 1, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_CNOT, 0, 1, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_CNOT, 2, 7, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_CNOT, 1, 1, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_BAD, 7, 7, -1, -1, -1, -1));
        queue_cmd(make_cmd(qgu_pkg::MODE_BAD, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 3, 5, rand_amp(), rand_amp(), rand_amp(),
                           rand_amp()));
        queue_cmd(make_cmd(qgu_pkg::MODE_X, 3, 5, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_H, 7, 0, 0, 0, 0, 0));
        wait_idle();

        set_qubit_limit(2);
        @(negedge clk);
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 2, 0, 1, 1, 1, 1));
        queue_cmd(make_cmd(qgu_pkg::MODE_X, 5, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_CNOT, 0, 3, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_CNOT, 3, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_BAD, 1, 1, 0, 0, 0, 0));
        wait_idle();

        // nothing is in range at zero qubits
        set_qubit_limit(0);
        @(negedge clk);
        queue_cmd(make_cmd(qgu_pkg::MODE_X, 0, 0, 0, 0, 0, 0));
        queue_cmd(make_cmd(qgu_pkg::MODE_LOAD, 0, 0, 5, 5, 5, 5));
        wait_idle();

        // Random phases: qubit_count, sender idle %, receiver stall %, commands
        run_random_phase(8, 0, 0, 110);
        run_random_phase(5, 53, 0, 90);
        run_random_phase(8, 0, 53, 100);
        run_random_phase(1, 20, 20, 40);
        run_random_phase(8, 20, 20, 80);

        $display("Ran %0d commands (%0d CNOT, %0d rejected), checked %0d results",
                 cmds_accepted, cnots_issued, cmds_rejected, results_checked);
        $display("over %0d qubit_count writes and four handshake pressure mixes",
                 limits_applied);
        if (mismatches == 0 && gate_results_q.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/qgu_pkg.sv
sv/qgu_if.sv
sv/qgu_amp_mem.sv
sv/qgu_gate_calc.sv
sv/qgu_out_buf.sv
sv/qubit_gate_unit_top.sv
sv/qgu_checker.sv
sim/qubit_gate_unit_top_tb.sv
